// File: rtl/core/assert_macros.svh
// Assertion macros shared by the connection engine RTL.
// Each macro wraps one clocked concurrent assertion with a disable iff guard on rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge of clk, ignored while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that an antecedent implies a consequent in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/tce_pkg.sv
// Shared types and constants for the TCP client connection engine.
// Has no dependencies; used by tce_step and tcp_connection_engine.
package tce_pkg;

  localparam logic [1:0] CMD_CONNECT = 2'd0;
  localparam logic [1:0] CMD_SEND    = 2'd1;
  localparam logic [1:0] CMD_SEGMENT = 2'd2;
  localparam logic [1:0] CMD_READ    = 2'd3;

  localparam logic [1:0] PH_CLOSED      = 2'd0;
  localparam logic [1:0] PH_SYN_SENT    = 2'd1;
  localparam logic [1:0] PH_ESTABLISHED = 2'd2;
  localparam logic [1:0] PH_FIN_WAIT    = 2'd3;

  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_NOT_CONNECTED = 3'd1;
  localparam logic [2:0] ST_WOULD_BLOCK   = 3'd2;
  localparam logic [2:0] ST_IN_PROGRESS   = 3'd3;
  localparam logic [2:0] ST_NOT_PERMITTED = 3'd4;
  localparam logic [2:0] ST_REFUSED       = 3'd5;

  localparam logic KIND_STATUS  = 1'b0;
  localparam logic KIND_SEGMENT = 1'b1;

  localparam logic [7:0] FL_FIN     = 8'h01;
  localparam logic [7:0] FL_SYN     = 8'h02;
  localparam logic [7:0] FL_RST     = 8'h04;
  localparam logic [7:0] FL_ACK     = 8'h10;
  localparam logic [7:0] FL_SYN_ACK = 8'h12;
  localparam logic [7:0] FL_PSH_ACK = 8'h18;

  localparam logic [15:0] MAX_CHUNK    = 16'd1400;
  localparam logic [15:0] PORT_BASE    = 16'd49152;
  localparam logic [15:0] WINDOW_MAX   = 16'hFFFF;
  localparam logic [31:0] ISN_BASE     = 32'h5000_0000;
  localparam int          ISN_PROC_SH  = 12;
  localparam logic [31:0] ISN_SOCK_MUL = 32'd97;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] peer_address;
    logic [15:0] peer_port;
    logic [15:0] arrival_dest_port;
    logic [31:0] arrival_seq;
    logic [31:0] arrival_ack;
    logic [7:0]  arrival_flags;
    logic [15:0] byte_length;
    logic        egress_permitted;
    logic [19:0] process_number;
    logic [7:0]  socket_number;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [2:0]  status;
    logic [15:0] length;
    logic [15:0] out_local_port;
    logic [31:0] out_remote_address;
    logic [15:0] out_remote_port;
    logic [31:0] out_seq;
    logic [31:0] out_ack;
    logic [15:0] out_window;
    logic [7:0]  out_flags;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [31:0] remote_address;
    logic [15:0] remote_port;
    logic [15:0] local_port;
    logic [15:0] next_eph_port;
    logic [31:0] send_seq;
    logic [31:0] recv_ack;
    logic        refused;
    logic        fin_rcvd;
  } conn_state_t;

endpackage

// File: rtl/core/tce_step.sv
// Per-event logic of the connection engine: next connection state and up to two results.
// Depends on tce_pkg for the item, result and state types and the protocol constants.
module tce_step #(
  parameter int RX_BUFFER_BYTES = 4096,
  parameter int OCC_W           = 13
) (
  input  tce_pkg::conn_state_t state_i,
  input  logic [OCC_W-1:0]     occ_i,
  input  tce_pkg::in_item_t    item_i,
  output tce_pkg::conn_state_t state_o,
  output logic [OCC_W-1:0]     occ_o,
  output tce_pkg::out_item_t   res0_o,
  output tce_pkg::out_item_t   res1_o,
  output logic [1:0]           count_o
);
  import tce_pkg::*;

  localparam logic [OCC_W-1:0] CAP = OCC_W'(RX_BUFFER_BYTES);

  function automatic logic [OCC_W-1:0] room_of(input logic [OCC_W-1:0] occ);
    return (occ >= CAP) ? '0 : CAP - occ;
  endfunction

  function automatic logic [15:0] window_of(input logic [OCC_W-1:0] room);
    logic [31:0] room32;
    room32 = 32'(room);
    return (room32 > 32'(WINDOW_MAX)) ? WINDOW_MAX : room32[15:0];
  endfunction

  function automatic out_item_t mk_status(input logic [2:0] st, input logic [15:0] len);
    out_item_t r;
    r = '0;
    r.result_kind = KIND_STATUS;
    r.status = st;
    r.length = len;
    return r;
  endfunction

  function automatic out_item_t mk_segment(input conn_state_t s, input logic [7:0] flags,
                                           input logic [31:0] seq, input logic [31:0] ack,
                                           input logic [15:0] win, input logic [15:0] len);
    out_item_t r;
    r = '0;
    r.result_kind = KIND_SEGMENT;
    r.length = len;
    r.out_local_port = s.local_port;
    r.out_remote_address = s.remote_address;
    r.out_remote_port = s.remote_port;
    r.out_seq = seq;
    r.out_ack = ack;
    r.out_window = win;
    r.out_flags = flags;
    return r;
  endfunction

  logic [OCC_W-1:0] room_cur;
  logic [15:0]      win_cur;
  logic [31:0]      isn;
  logic [15:0]      eph_inc;
  logic [15:0]      eph_next;
  logic [15:0]      chunk;
  logic             match;
  logic             syn_ack_ok;
  logic [31:0]      rx_take;
  logic [OCC_W-1:0] occ_after_rx;
  logic [15:0]      win_after_rx;
  logic [31:0]      ack_data;
  logic [31:0]      ack_fin;
  logic [15:0]      rd_take;
  logic [OCC_W-1:0] occ_after_rd;
  logic [15:0]      win_after_rd;
  out_item_t        seg_data;
  out_item_t        seg_fin;

  assign room_cur = room_of(occ_i);
  assign win_cur  = window_of(room_cur);
  assign isn      = ISN_BASE + {item_i.process_number, ISN_PROC_SH'(0)}
                  + 32'(item_i.socket_number) * ISN_SOCK_MUL;
  assign eph_inc  = state_i.next_eph_port + 16'd1;
  assign eph_next = (eph_inc < PORT_BASE) ? PORT_BASE : eph_inc;
  assign chunk    = (item_i.byte_length > MAX_CHUNK) ? MAX_CHUNK : item_i.byte_length;

  assign match = (state_i.local_port == item_i.arrival_dest_port)
              && (state_i.remote_address == item_i.peer_address)
              && (state_i.remote_port == item_i.peer_port);
  assign syn_ack_ok = (state_i.phase == PH_SYN_SENT)
                   && ((item_i.arrival_flags & FL_SYN_ACK) == FL_SYN_ACK)
                   && (item_i.arrival_ack == state_i.send_seq);

  assign rx_take = (32'(item_i.byte_length) < 32'(room_cur)) ? 32'(item_i.byte_length)
                                                             : 32'(room_cur);
  assign occ_after_rx = occ_i + OCC_W'(rx_take);
  assign win_after_rx = window_of(room_of(occ_after_rx));
  assign ack_data     = item_i.arrival_seq + rx_take;
  assign ack_fin      = item_i.arrival_seq + 32'(item_i.byte_length) + 32'd1;

  assign rd_take = (32'(occ_i) < 32'(item_i.byte_length)) ? 16'(occ_i)
                                                          : item_i.byte_length;
  assign occ_after_rd = occ_i - OCC_W'(rd_take);
  assign win_after_rd = window_of(room_of(occ_after_rd));

  always_comb begin
    if (rx_take != 32'd0) begin
      seg_data = mk_segment(state_i, FL_ACK, state_i.send_seq, ack_data, win_after_rx, 16'd0);
    end else begin
      seg_data = mk_segment(state_i, FL_ACK, state_i.send_seq, state_i.recv_ack, 16'd0, 16'd0);
    end
    seg_fin = mk_segment(state_i, FL_ACK, state_i.send_seq, ack_fin, win_after_rx, 16'd0);
  end

  always_comb begin
    state_o = state_i;
    occ_o   = occ_i;
    res0_o  = '0;
    res1_o  = '0;
    count_o = 2'd0;
    unique case (item_i.command)
      CMD_CONNECT: begin
        if (state_i.phase == PH_ESTABLISHED) begin
          res0_o  = mk_status(ST_OK, 16'd0);
          count_o = 2'd1;
        end else if (!item_i.egress_permitted) begin
          res0_o  = mk_status(ST_NOT_PERMITTED, 16'd0);
          count_o = 2'd1;
        end else if (state_i.phase == PH_CLOSED) begin
          state_o.remote_address = item_i.peer_address;
          state_o.remote_port    = item_i.peer_port;
          state_o.local_port     = state_i.next_eph_port;
          state_o.next_eph_port  = eph_next;
          state_o.send_seq       = isn + 32'd1;
          state_o.recv_ack       = '0;
          state_o.refused        = 1'b0;
          state_o.fin_rcvd       = 1'b0;
          state_o.phase          = PH_SYN_SENT;
          res0_o  = mk_segment(state_o, FL_SYN, isn, 32'd0, win_cur, 16'd0);
          res1_o  = mk_status(ST_IN_PROGRESS, 16'd0);
          count_o = 2'd2;
        end else begin
          res0_o  = mk_status(state_i.refused ? ST_REFUSED : ST_IN_PROGRESS, 16'd0);
          count_o = 2'd1;
        end
      end
      CMD_SEND: begin
        if (state_i.phase != PH_ESTABLISHED) begin
          res0_o  = mk_status(ST_NOT_CONNECTED, 16'd0);
          count_o = 2'd1;
        end else if (item_i.byte_length == 16'd0) begin
          res0_o  = mk_status(ST_OK, 16'd0);
          count_o = 2'd1;
        end else begin
          res0_o  = mk_segment(state_i, FL_PSH_ACK, state_i.send_seq, state_i.recv_ack,
                               win_cur, chunk);
          res1_o  = mk_status(ST_OK, chunk);
          count_o = 2'd2;
          state_o.send_seq = state_i.send_seq + 32'(chunk);
        end
      end
      CMD_SEGMENT: begin
        if (!match) begin
          count_o = 2'd0;
        end else if (syn_ack_ok) begin
          state_o.recv_ack = item_i.arrival_seq + 32'd1;
          state_o.phase    = PH_ESTABLISHED;
          res0_o  = mk_segment(state_i, FL_ACK, state_i.send_seq, state_o.recv_ack,
                               win_cur, 16'd0);
          count_o = 2'd1;
        end else if (state_i.phase != PH_ESTABLISHED && state_i.phase != PH_FIN_WAIT) begin
          count_o = 2'd0;
        end else if ((item_i.arrival_flags & FL_RST) != 8'd0) begin
          state_o.refused = 1'b1;
        end else begin
          occ_o = occ_after_rx;
          if ((item_i.arrival_flags & FL_FIN) != 8'd0) begin
            state_o.fin_rcvd = 1'b1;
            state_o.recv_ack = ack_fin;
          end else if (rx_take != 32'd0) begin
            state_o.recv_ack = ack_data;
          end
          if (item_i.byte_length != 16'd0) begin
            res0_o = seg_data;
            if ((item_i.arrival_flags & FL_FIN) != 8'd0) begin
              res1_o  = seg_fin;
              count_o = 2'd2;
            end else begin
              count_o = 2'd1;
            end
          end else if ((item_i.arrival_flags & FL_FIN) != 8'd0) begin
            res0_o  = seg_fin;
            count_o = 2'd1;
          end
        end
      end
      CMD_READ: begin
        if (state_i.refused) begin
          res0_o  = mk_status(ST_REFUSED, 16'd0);
          count_o = 2'd1;
        end else if (occ_i == '0) begin
          res0_o  = mk_status(state_i.fin_rcvd ? ST_OK : ST_WOULD_BLOCK, 16'd0);
          count_o = 2'd1;
        end else begin
          occ_o = occ_after_rd;
          if (state_i.phase == PH_ESTABLISHED || state_i.phase == PH_FIN_WAIT) begin
            res0_o  = mk_segment(state_i, FL_ACK, state_i.send_seq, state_i.recv_ack,
                                 win_after_rd, 16'd0);
            res1_o  = mk_status(ST_OK, rd_take);
            count_o = 2'd2;
          end else begin
            res0_o  = mk_status(ST_OK, rd_take);
            count_o = 2'd1;
          end
        end
      end
      default: begin
        count_o = 2'd0;
      end
    endcase
    if (count_o == 2'd1) begin
      res0_o.last = 1'b1;
    end else if (count_o == 2'd2) begin
      res1_o.last = 1'b1;
    end
  end

endmodule

// File: rtl/core/tcp_connection_engine.sv
// Single-connection TCP client engine: connect, send, segment arrival and read events go in
// on the in_ channel, and status replies and outgoing segment headers come out on the out_
// channel, zero, one or two per event with last marking the final one. Depends on tce_pkg,
// tce_step and assert_macros.svh. An event is taken into an input register, worked by the
// combinational tce_step and its results written into a four-entry result queue, so the
// first result is presented only after both the input register and the queue write. The
// queue drains one result per cycle while out_stall is low: events with one result sustain
// one per cycle, while events with two results fill the queue until the input stalls. The
// input stalls only while the queue holds more than two results.
`include "assert_macros.svh"

module tcp_connection_engine #(
  parameter int RX_BUFFER_BYTES = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tce_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tce_pkg::out_item_t  out_data
);
  import tce_pkg::*;

  localparam int OCC_W = $clog2(RX_BUFFER_BYTES + 1);

  in_item_t                item_r;
  logic                    full_r;
  logic                    full_nxt;
  conn_state_t             state_r;
  conn_state_t             state_nxt;
  logic [OCC_W-1:0]        occ_r;
  logic [OCC_W-1:0]        occ_nxt;
  out_item_t               res0;
  out_item_t               res1;
  logic [1:0]              res_cnt;
  out_item_t               fifo_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_r;
  logic [FIFO_PTR_W-1:0]   wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0]   rd_ptr_r;
  logic [FIFO_PTR_W-1:0]   rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0]   count_r;
  logic [FIFO_CNT_W-1:0]   count_nxt;
  logic                    proc;
  logic                    accept;
  logic                    pop;
  logic [FIFO_CNT_W-1:0]   push_cnt;

  tce_step #(
    .RX_BUFFER_BYTES(RX_BUFFER_BYTES),
    .OCC_W          (OCC_W)
  ) u_step (
    .state_i(state_r),
    .occ_i  (occ_r),
    .item_i (item_r),
    .state_o(state_nxt),
    .occ_o  (occ_nxt),
    .res0_o (res0),
    .res1_o (res1),
    .count_o(res_cnt)
  );

  assign proc      = full_r && (count_r <= FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign in_stall  = full_r && !proc;
  assign accept    = in_valid && !in_stall;
  assign full_nxt  = accept || (full_r && !proc);
  assign out_valid = (count_r != '0);
  assign out_data  = fifo_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign push_cnt  = proc ? FIFO_CNT_W'(res_cnt) : '0;
  assign count_nxt = count_r + push_cnt - FIFO_CNT_W'(pop);
  assign wr_ptr_nxt = wr_ptr_r + FIFO_PTR_W'(push_cnt);
  assign rd_ptr_nxt = rd_ptr_r + FIFO_PTR_W'(pop);

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    if (proc && res_cnt != 2'd0) begin
      fifo_r[wr_ptr_r] <= res0;
    end
    if (proc && res_cnt == 2'd2) begin
      fifo_r[wr_ptr_r + FIFO_PTR_W'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r   <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      state_r  <= '{phase: PH_CLOSED, next_eph_port: PORT_BASE, default: '0};
      occ_r    <= '0;
    end else begin
      full_r   <= full_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
      if (proc) begin
        state_r <= state_nxt;
        occ_r   <= occ_nxt;
      end
    end
  end

  `ASSERT_CLK(a_queue_bound, count_r <= FIFO_CNT_W'(FIFO_DEPTH),
    "result queue holds more entries than it has")
  `ASSERT_CLK(a_occ_bound, 32'(occ_r) <= 32'(RX_BUFFER_BYTES),
    "receive occupancy above buffer size")
  `ASSERT_CLK(a_eph_range, state_r.next_eph_port >= PORT_BASE,
    "ephemeral port counter left its range")
  `ASSERT_CLK(a_open_port, state_r.phase == PH_CLOSED || state_r.local_port >= PORT_BASE,
    "open connection without an ephemeral local port")
  `ASSERT_NEXT(a_drain, pop && !proc, count_r == $past(count_r) - FIFO_CNT_W'(1),
    "result transfer did not shrink the queue")

endmodule

// File: bench/tcp_connection_engine_checker.sv
`timescale 1ns / 100ps
// Result checker for the TCP client connection engine: watches both channels,
// predicts every reply and segment header, and compares them in order.
// Depends on tce_pkg for the item types, commands, phases, flags and codes.
module tcp_connection_engine_checker #(
  parameter int RX_BUFFER_BYTES = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  tce_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  tce_pkg::out_item_t out_data,
  output int                 mismatches,
  output int                 outstanding,
  output int                 results_checked
);
  import tce_pkg::*;

  logic [1:0]  phase;
  logic [31:0] peer_addr;
  logic [15:0] peer_port;
  logic [15:0] own_port;
  logic [15:0] eph_port;
  logic [31:0] snd_nxt;
  logic [31:0] rcv_nxt;
  logic        refused;
  logic        fin_seen;
  int          rx_fill;

  out_item_t awaited_results [$];
  out_item_t want;
  out_item_t got;

  function automatic int free_bytes();
    return (rx_fill >= RX_BUFFER_BYTES) ? 0 : RX_BUFFER_BYTES - rx_fill;
  endfunction

  function automatic logic [15:0] open_window();
    int room = free_bytes();
    return (room > 65535) ? WINDOW_MAX : 16'(room);
  endfunction

  function automatic out_item_t status_reply(logic [2:0] code, logic [15:0] len);
    out_item_t r = '0;
    r.result_kind = KIND_STATUS;
    r.status = code;
    r.length = len;
    return r;
  endfunction

  function automatic out_item_t segment_reply(logic [7:0] flags, logic [31:0] seq,
                                              logic [31:0] ack, logic [15:0] win,
                                              logic [15:0] len);
    out_item_t r = '0;
    r.result_kind = KIND_SEGMENT;
    r.length = len;
    r.out_local_port = own_port;
    r.out_remote_address = peer_addr;
    r.out_remote_port = peer_port;
    r.out_seq = seq;
    r.out_ack = ack;
    r.out_window = win;
    r.out_flags = flags;
    return r;
  endfunction

  task automatic predict_replies(input in_item_t ev);
    out_item_t   batch [$];
    logic [15:0] chunk;
    int          room;
    int          take;
    batch = {};
    case (ev.command)
      CMD_CONNECT: begin
        if (phase == PH_ESTABLISHED) begin
          batch.push_back(status_reply(ST_OK, 16'd0));
        end else if (!ev.egress_permitted) begin
          batch.push_back(status_reply(ST_NOT_PERMITTED, 16'd0));
        end else begin
          if (phase == PH_CLOSED) begin
            peer_addr = ev.peer_address;
            peer_port = ev.peer_port;
            own_port = eph_port;
            eph_port = eph_port + 16'd1;
            if (eph_port < PORT_BASE) eph_port = PORT_BASE;
            snd_nxt = ISN_BASE + (32'(ev.process_number) << ISN_PROC_SH) +
                      32'(ev.socket_number) * ISN_SOCK_MUL;
            rcv_nxt = '0;
            refused = 1'b0;
            fin_seen = 1'b0;
            phase = PH_SYN_SENT;
            batch.push_back(segment_reply(FL_SYN, snd_nxt, 32'd0, open_window(), 16'd0));
            snd_nxt = snd_nxt + 32'd1;
          end
          batch.push_back(status_reply(refused ? ST_REFUSED : ST_IN_PROGRESS, 16'd0));
        end
      end
      CMD_SEND: begin
        if (phase != PH_ESTABLISHED) begin
          batch.push_back(status_reply(ST_NOT_CONNECTED, 16'd0));
        end else if (ev.byte_length == 16'd0) begin
          batch.push_back(status_reply(ST_OK, 16'd0));
        end else begin
          chunk = (ev.byte_length > MAX_CHUNK) ? MAX_CHUNK : ev.byte_length;
          batch.push_back(segment_reply(FL_PSH_ACK, snd_nxt, rcv_nxt, open_window(), chunk));
          snd_nxt = snd_nxt + 32'(chunk);
          batch.push_back(status_reply(ST_OK, chunk));
        end
      end
      CMD_SEGMENT: begin
        if (own_port == ev.arrival_dest_port && peer_addr == ev.peer_address &&
            peer_port == ev.peer_port) begin
          if (phase == PH_SYN_SENT && (ev.arrival_flags & FL_SYN_ACK) == FL_SYN_ACK &&
              ev.arrival_ack == snd_nxt) begin
            rcv_nxt = ev.arrival_seq + 32'd1;
            phase = PH_ESTABLISHED;
            batch.push_back(segment_reply(FL_ACK, snd_nxt, rcv_nxt, open_window(), 16'd0));
          end else if (phase == PH_ESTABLISHED || phase == PH_FIN_WAIT) begin
            if ((ev.arrival_flags & FL_RST) != 8'd0) begin
              refused = 1'b1;
            end else begin
              if (ev.byte_length != 16'd0) begin
                room = free_bytes();
                take = (int'(ev.byte_length) < room) ? int'(ev.byte_length) : room;
                if (take != 0) begin
                  rx_fill += take;
                  rcv_nxt = ev.arrival_seq + 32'(take);
                  batch.push_back(segment_reply(FL_ACK, snd_nxt, rcv_nxt, open_window(),
                                                16'd0));
                end else begin
                  batch.push_back(segment_reply(FL_ACK, snd_nxt, rcv_nxt, 16'd0, 16'd0));
                end
              end
              if ((ev.arrival_flags & FL_FIN) != 8'd0) begin
                fin_seen = 1'b1;
                rcv_nxt = ev.arrival_seq + 32'(ev.byte_length) + 32'd1;
                batch.push_back(segment_reply(FL_ACK, snd_nxt, rcv_nxt, open_window(),
                                              16'd0));
              end
            end
          end
        end
      end
      default: begin
        if (refused) begin
          batch.push_back(status_reply(ST_REFUSED, 16'd0));
        end else if (rx_fill == 0) begin
          batch.push_back(status_reply(fin_seen ? ST_OK : ST_WOULD_BLOCK, 16'd0));
        end else begin
          take = (rx_fill < int'(ev.byte_length)) ? rx_fill : int'(ev.byte_length);
          rx_fill -= take;
          if (phase == PH_ESTABLISHED || phase == PH_FIN_WAIT) begin
            batch.push_back(segment_reply(FL_ACK, snd_nxt, rcv_nxt, open_window(), 16'd0));
          end
          batch.push_back(status_reply(ST_OK, 16'(take)));
        end
      end
    endcase
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) awaited_results.push_back(batch[i]);
  endtask

  function automatic int field_diff(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      phase = PH_CLOSED;
      peer_addr = '0;
      peer_port = '0;
      own_port = '0;
      eph_port = PORT_BASE;
      snd_nxt = '0;
      rcv_nxt = '0;
      refused = 1'b0;
      fin_seen = 1'b0;
      rx_fill = 0;
      awaited_results.delete();
    end else begin
      if (in_valid && !in_stall) predict_replies(in_data);
      if (out_valid && !out_stall) begin
        got = out_data;
        results_checked++;
        if (awaited_results.size() == 0) begin
          $error("result transfer with nothing expected: 0x%0h", got);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          mismatches += field_diff("result_kind", 32'(want.result_kind), 32'(got.result_kind));
          mismatches += field_diff("status", 32'(want.status), 32'(got.status));
          mismatches += field_diff("length", 32'(want.length), 32'(got.length));
          mismatches += field_diff("out_local_port", 32'(want.out_local_port),
                                   32'(got.out_local_port));
          mismatches += field_diff("out_remote_address", want.out_remote_address,
                                   got.out_remote_address);
          mismatches += field_diff("out_remote_port", 32'(want.out_remote_port),
                                   32'(got.out_remote_port));
          mismatches += field_diff("out_seq", want.out_seq, got.out_seq);
          mismatches += field_diff("out_ack", want.out_ack, got.out_ack);
          mismatches += field_diff("out_window", 32'(want.out_window), 32'(got.out_window));
          mismatches += field_diff("out_flags", 32'(want.out_flags), 32'(got.out_flags));
          mismatches += field_diff("last", 32'(want.last), 32'(got.last));
        end
      end
    end
    outstanding = awaited_results.size();
  end

endmodule

// File: bench/tcp_connection_engine_test.sv
`timescale 1ns / 100ps
// Top of the connection engine testbench: clock, reset, event stimulus with random
// idling and output stalls, and the final verdict. Depends on tce_pkg, the engine
// and tcp_connection_engine_checker.
module tcp_connection_engine_test;
  import tce_pkg::*;

  localparam int          RX_BYTES      = 4096;
  localparam int          RESET_CYCLES  = 8;
  localparam int          RANDOM_EVENTS = 750;
  localparam int          CALM_EVENTS   = 100;
  localparam int          DRAIN_CYCLES  = 16;
  localparam int          CYCLE_LIMIT   = 400000;
  localparam logic [31:0] PEER_ADDR     = 32'hFFFF_FFFF;
  localparam logic [15:0] PEER_PORT     = 16'hFFFF;
  localparam logic [19:0] OWNER_PID     = 20'hF_FFFF;
  localparam logic [7:0]  OWNER_FD      = 8'hFF;
  localparam logic [31:0] FIRST_SEQ     = ISN_BASE + (32'(OWNER_PID) << ISN_PROC_SH) +
                                          32'(OWNER_FD) * ISN_SOCK_MUL;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int mismatches;
  int outstanding;
  int results_checked;
  int events_sent = 0;
  int cycle_count = 0;
  int idle_odds = 3;
  bit calm = 1'b0;

  tcp_connection_engine #(.RX_BUFFER_BYTES(RX_BYTES)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  tcp_connection_engine_checker #(.RX_BUFFER_BYTES(RX_BYTES)) result_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .results_checked(results_checked)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tcp_connection_engine regression: fail");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!calm && rst_n && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
        if ($urandom_range(0, 5) == 0) repeat ($urandom_range(30, 120)) @(posedge clk);
      end
    end
  end

  function automatic in_item_t make_event(logic [1:0] cmd, logic [15:0] len);
    in_item_t ev;
    ev.command = cmd;
    ev.peer_address = $urandom();
    ev.peer_port = 16'($urandom());
    ev.arrival_dest_port = 16'($urandom());
    ev.arrival_seq = $urandom();
    ev.arrival_ack = $urandom();
    ev.arrival_flags = 8'($urandom());
    ev.byte_length = len;
    ev.egress_permitted = 1'($urandom());
    ev.process_number = 20'($urandom());
    ev.socket_number = 8'($urandom());
    return ev;
  endfunction

  function automatic in_item_t peer_segment(logic [7:0] flags, logic [15:0] len);
    in_item_t ev = make_event(CMD_SEGMENT, len);
    ev.peer_address = PEER_ADDR;
    ev.peer_port = PEER_PORT;
    ev.arrival_dest_port = PORT_BASE;
    ev.arrival_flags = flags;
    return ev;
  endfunction

  function automatic in_item_t connect_event(logic permit);
    in_item_t ev = make_event(CMD_CONNECT, 16'($urandom()));
    ev.peer_address = PEER_ADDR;
    ev.peer_port = PEER_PORT;
    ev.egress_permitted = permit;
    ev.process_number = OWNER_PID;
    ev.socket_number = OWNER_FD;
    return ev;
  endfunction

  function automatic logic [15:0] sized_length(int common_max);
    if ($urandom_range(0, 19) == 0) return 16'($urandom());
    return 16'($urandom_range(0, common_max));
  endfunction

  task automatic send_event(input in_item_t ev);
    in_data <= ev;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    events_sent++;
    if (!calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  initial begin
    in_item_t ev;
    int       pick;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Closed connection: nothing is open yet.
    send_event(make_event(CMD_SEND, 16'd100));
    send_event(make_event(CMD_READ, 16'd50));
    ev = make_event(CMD_SEGMENT, 16'd0);
    ev.peer_address = '0;
    ev.peer_port = '0;
    ev.arrival_dest_port = '0;
    ev.arrival_ack = '0;
    ev.arrival_flags = FL_SYN_ACK;
    send_event(ev);
    send_event(connect_event(1'b0));
    send_event(connect_event(1'b1));

    // Handshake pending.
    send_event(make_event(CMD_SEND, 16'd10));
    send_event(connect_event(1'b1));
    ev = peer_segment(FL_SYN_ACK, 16'd0);
    ev.arrival_ack = FIRST_SEQ;
    send_event(ev);
    send_event(peer_segment(FL_RST, 16'd0));
    ev = peer_segment(FL_SYN_ACK, 16'd0);
    ev.arrival_ack = FIRST_SEQ + 32'd1;
    ev.arrival_dest_port = PORT_BASE + 16'd1;
    send_event(ev);
    ev = peer_segment(FL_SYN_ACK, 16'd0);
    ev.arrival_ack = FIRST_SEQ + 32'd1;
    ev.arrival_seq = '1;
    send_event(ev);

    // Established connection.
    send_event(make_event(CMD_READ, 16'd10));
    send_event(make_event(CMD_SEND, 16'd0));
    send_event(make_event(CMD_SEND, 16'hFFFF));
    send_event(make_event(CMD_SEND, 16'd1));
    send_event(peer_segment(8'h00, 16'hFFFF));
    send_event(peer_segment(FL_ACK, 16'd10));
    send_event(make_event(CMD_READ, 16'd0));
    send_event(make_event(CMD_READ, 16'hFFFF));
    send_event(connect_event(1'b1));
    send_event(peer_segment(FL_FIN, 16'd100));
    send_event(make_event(CMD_READ, 16'hFFFF));
    send_event(make_event(CMD_READ, 16'd20));

    for (int i = 0; i < RANDOM_EVENTS; i++) begin
      if (i % 50 == 0) idle_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 5);
      if (i == RANDOM_EVENTS - CALM_EVENTS) calm = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        ev = peer_segment(8'($urandom()) & ~FL_RST, sized_length(1500));
      end else if (pick < 55) begin
        ev = make_event(CMD_READ, sized_length(3000));
      end else if (pick < 75) begin
        ev = make_event(CMD_SEND, sized_length(2000));
      end else if (pick < 85) begin
        ev = make_event(CMD_CONNECT, 16'($urandom()));
      end else begin
        ev = make_event(2'($urandom_range(0, 3)), 16'($urandom()));
        if (ev.arrival_dest_port == PORT_BASE) ev.arrival_dest_port = ~PORT_BASE;
      end
      send_event(ev);
    end

    // Refusal: the reset ignores the payload and FIN that ride with it.
    send_event(peer_segment(FL_RST | FL_FIN, 16'd300));
    send_event(make_event(CMD_READ, 16'd100));
    send_event(make_event(CMD_SEND, 16'd10));
    send_event(connect_event(1'b1));
    send_event(connect_event(1'b0));
    send_event(make_event(CMD_READ, 16'd0));
    in_valid <= 1'b0;

    do @(negedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Drove %0d events through the closed, handshake, established and refused phases.",
             events_sent);
    $display("Checked %0d replies and segment headers in order, field by field.",
             results_checked);
    if (mismatches == 0) begin
      $display("tcp_connection_engine regression: pass");
    end else begin
      $display("tcp_connection_engine regression: fail");
    end
    $finish;
  end

endmodule
